@@ sv/rff_pkg.sv @@
// rff_pkg: shared widths, limits and register codes for the repulsive field force block
// no dependencies; imported by repulsive_field_force
package rff_pkg;

  localparam int unsigned PosW     = 32;  // signed position fields
  localparam int unsigned RadW     = 31;  // unsigned radius fields and registers
  localparam int unsigned GainW    = 32;  // gain register
  localparam int unsigned MagW     = 33;  // magnitude of one offset component
  localparam int unsigned SqW      = 65;  // square of one magnitude
  localparam int unsigned SumW     = 66;  // sum of three squares
  localparam int unsigned RootW    = 33;  // integer norm
  localparam int unsigned DW       = 31;  // clearance d and D - d
  localparam int unsigned GeW      = GainW + DW;   // gain * (D - d)
  localparam int unsigned NbW      = GeW + MagW;   // gain * (D - d) * |r_i|
  localparam int unsigned DenW     = 5 * DW + 2;   // d^3 * D * n
  localparam int unsigned QW       = 48;  // quotient bits
  localparam int unsigned OutW     = 48;  // force fields
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgAgentRadius  = 2'd0,
    CfgDetectRadius = 2'd1,
    CfgRepelGain    = 2'd2
  } cfg_idx_e;

endpackage

@@ sv/repulsive_field_force.sv @@
// repulsive_field_force: pipelined repulsive potential-field force of one obstacle
// depends on rff_pkg (widths, output limits, register codes)
//
//  channel | handshake                     | payload
//  --------+-------------------------------+-------------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//  in      | in_valid_i  / in_stall_o      | robot_*_i, obstacle_*_i, obstacle_radius_i
//  out     | out_valid_o / out_stall_i     | force_*_o, saturated_o
//
// one transaction per cycle in and out while not stalled; the pipe holds 33 square-root stages,
// 48 divider stages and 14 stages of differencing, squaring and product building.
// all stages move together; a stalled result at the output freezes the whole pipe,
// so in_stall_o follows out_stall_i while the last stage holds a result.
// reset clears the stage valid bits and loads the register defaults.
module repulsive_field_force
  import rff_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PosW-1:0]     robot_x_i,
  input  logic [PosW-1:0]     robot_y_i,
  input  logic [PosW-1:0]     robot_z_i,
  input  logic [PosW-1:0]     obstacle_x_i,
  input  logic [PosW-1:0]     obstacle_y_i,
  input  logic [PosW-1:0]     obstacle_z_i,
  input  logic [RadW-1:0]     obstacle_radius_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutW-1:0]     force_x_o,
  output logic [OutW-1:0]     force_y_o,
  output logic [OutW-1:0]     force_z_o,
  output logic                saturated_o
);

  localparam int unsigned NumW  = NbW + 3 * FRAC_BITS;
  localparam int unsigned HiW   = NumW - QW;
  localparam int unsigned TW    = 2 * RootW + 2;
  localparam int unsigned D3W   = 3 * DW;
  localparam int unsigned D4W   = 4 * DW;
  localparam int unsigned SqEnd = 2 + RootW;
  localparam int unsigned NSt   = SqEnd + 11 + QW + 1;

  // ---------------- configuration
  logic [RadW-1:0]  agent_q, detect_q;
  logic [GainW-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agent_q  <= '0;
      detect_q <= RadW'(1) << FRAC_BITS;
      gain_q   <= GainW'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgAgentRadius:  agent_q  <= cfg_data_i[RadW-1:0];
        CfgDetectRadius: detect_q <= cfg_data_i[RadW-1:0];
        CfgRepelGain:    gain_q   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage valid bits and global advance
  logic [NSt-1:0] vld_q;
  logic           adv;

  assign adv         = !(vld_q[NSt-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], in_valid_i};
    end
  end

  // ---------------- stage A: offsets and magnitudes
  logic [PosW-1:0] rob [3];
  logic [PosW-1:0] obs [3];
  logic [MagW-1:0] a_diff [3];
  logic [2:0]      a_neg_q;
  logic [MagW-1:0] a_mag_q [3];
  logic [RadW:0]   a_rs_q;

  assign rob[0] = robot_x_i;
  assign rob[1] = robot_y_i;
  assign rob[2] = robot_z_i;
  assign obs[0] = obstacle_x_i;
  assign obs[1] = obstacle_y_i;
  assign obs[2] = obstacle_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_diff[i] = {rob[i][PosW-1], rob[i]} - {obs[i][PosW-1], obs[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_q[i] <= a_diff[i][MagW-1];
        a_mag_q[i] <= a_diff[i][MagW-1] ? (~a_diff[i] + MagW'(1)) : a_diff[i];
      end
      a_rs_q <= {1'b0, agent_q} + {1'b0, obstacle_radius_i};
    end
  end

  // ---------------- stage B: squares
  logic [2*MagW-1:0] b_prod [3];
  logic [SqW-1:0]    b_sq_q [3];
  logic [2:0]        b_neg_q;
  logic [MagW-1:0]   b_mag_q [3];
  logic [RadW:0]     b_rs_q;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign b_prod[i] = a_mag_q[i] * a_mag_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i] <= b_prod[i][SqW-1:0];
      end
      b_neg_q <= a_neg_q;
      b_mag_q <= a_mag_q;
      b_rs_q  <= a_rs_q;
    end
  end

  // ---------------- stage C (sqrt entry) and square root, one root bit per stage
  logic [SumW-1:0]  sq_rem_q  [RootW+1];
  logic [RootW-1:0] sq_root_q [RootW+1];
  logic [2:0]       sq_neg_q  [RootW+1];
  logic [MagW-1:0]  sq_mag_q  [RootW+1][3];
  logic [RadW:0]    sq_rs_q   [RootW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0]  <= SumW'(b_sq_q[0]) + SumW'(b_sq_q[1]) + SumW'(b_sq_q[2]);
      sq_root_q[0] <= '0;
      sq_neg_q[0]  <= b_neg_q;
      sq_mag_q[0]  <= b_mag_q;
      sq_rs_q[0]   <= b_rs_q;
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int unsigned Bit = RootW - 1 - k;
    logic [TW-1:0] term;
    logic          take;

    // (root + 2^Bit)^2 - root^2
    assign term = (TW'(sq_root_q[k]) << (Bit + 1)) + (TW'(1) << (2 * Bit));
    assign take = TW'(sq_rem_q[k]) >= term;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k+1]  <= take ? SumW'(TW'(sq_rem_q[k]) - term) : sq_rem_q[k];
        sq_root_q[k+1] <= take ? (sq_root_q[k] | (RootW'(1) << Bit)) : sq_root_q[k];
        sq_neg_q[k+1]  <= sq_neg_q[k];
        sq_mag_q[k+1]  <= sq_mag_q[k];
        sq_rs_q[k+1]   <= sq_rs_q[k];
      end
    end
  end

  // ---------------- E1/E2: clearance, clamp and detection test
  logic signed [RootW+1:0] e1_dd_q;
  logic                    e1_nz_q;
  logic [RootW-1:0]        e1_n_q;
  logic [2:0]              e1_neg_q;
  logic [MagW-1:0]         e1_mag_q [3];

  logic [RootW+1:0]        e2_dc;
  logic [DW-1:0]           e2_d_q, e2_e_q;
  logic                    e2_zero_q;
  logic [RootW-1:0]        e2_n_q;
  logic [2:0]              e2_neg_q;
  logic [MagW-1:0]         e2_mag_q [3];

  // d below one LSB is raised to one LSB
  assign e2_dc = (e1_dd_q[RootW+1] || (e1_dd_q == '0)) ? (RootW+2)'(1) : e1_dd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_dd_q   <= $signed({2'b0, sq_root_q[RootW]}) - $signed({3'b0, sq_rs_q[RootW]});
      e1_nz_q   <= |sq_root_q[RootW];
      e1_n_q    <= sq_root_q[RootW];
      e1_neg_q  <= sq_neg_q[RootW];
      e1_mag_q  <= sq_mag_q[RootW];

      e2_d_q    <= e2_dc[DW-1:0];
      e2_e_q    <= detect_q - e2_dc[DW-1:0];
      e2_zero_q <= !e1_nz_q || (e2_dc >= (RootW+2)'(detect_q));
      e2_n_q    <= e1_n_q;
      e2_neg_q  <= e1_neg_q;
      e2_mag_q  <= e1_mag_q;
    end
  end

  // ---------------- M1..M7: numerator and d^3 * D * n, 31-bit (DW) and 32-bit partial products
  logic [2*DW-1:0]      m1_d2_d, m1_d2_q;
  logic [GeW-1:0]       m1_ge_d, m1_ge_q;
  logic [DW-1:0]        m1_d_q;
  logic [RootW-1:0]     m1_n_q;
  logic                 m1_zero_q;
  logic [2:0]           m1_neg_q;
  logic [MagW-1:0]      m1_mag_q [3];

  logic [2*DW-1:0]      m2_p0_d, m2_p1_d, m2_p0_q, m2_p1_q;
  logic [32+MagW-1:0]   m2_g0_d [3];
  logic [32+MagW-1:0]   m2_g0_q [3];
  logic [GeW-32+MagW-1:0] m2_g1_d [3];
  logic [GeW-32+MagW-1:0] m2_g1_q [3];
  logic [RootW-1:0]     m2_n_q;
  logic                 m2_zero_q;
  logic [2:0]           m2_neg_q;

  logic [D3W-1:0]       m3_d3_q;
  logic [NbW-1:0]       m3_num_q [3];
  logic [RootW-1:0]     m3_n_q;
  logic                 m3_zero_q;
  logic [2:0]           m3_neg_q;

  logic [2*DW-1:0]      m4_dp_d [3];
  logic [2*DW-1:0]      m4_dp_q [3];
  logic [NbW-1:0]       m4_num_q [3];
  logic [RootW-1:0]     m4_n_q;
  logic                 m4_zero_q;
  logic [2:0]           m4_neg_q;

  logic [D4W-1:0]       m5_dd_d, m5_dd_q;
  logic [NbW-1:0]       m5_num_q [3];
  logic [RootW-1:0]     m5_n_q;
  logic                 m5_zero_q;
  logic [2:0]           m5_neg_q;

  logic [DW+RootW-1:0]  m6_np_d [4];
  logic [DW+RootW-1:0]  m6_np_q [4];
  logic [NbW-1:0]       m6_num_q [3];
  logic                 m6_zero_q;
  logic [2:0]           m6_neg_q;

  logic [DenW-1:0]      m7_den_d, m7_den_q;
  logic [NbW-1:0]       m7_num_q [3];
  logic                 m7_zero_q;
  logic [2:0]           m7_neg_q;

  assign m1_d2_d = e2_d_q * e2_d_q;
  assign m1_ge_d = gain_q * e2_e_q;
  assign m2_p0_d = m1_d2_q[DW-1:0] * m1_d_q;
  assign m2_p1_d = m1_d2_q[2*DW-1:DW] * m1_d_q;

  for (genvar i = 0; i < 3; i++) begin : g_num
    assign m2_g0_d[i] = m1_ge_q[31:0] * m1_mag_q[i];
    assign m2_g1_d[i] = m1_ge_q[GeW-1:32] * m1_mag_q[i];
    assign m4_dp_d[i] = m3_d3_q[i*DW +: DW] * detect_q;
  end

  for (genvar j = 0; j < 4; j++) begin : g_den
    assign m6_np_d[j] = m5_dd_q[j*DW +: DW] * m5_n_q;
  end

  always_comb begin
    m5_dd_d  = '0;
    m7_den_d = '0;
    for (int j = 0; j < 3; j++) begin
      m5_dd_d = m5_dd_d + (D4W'(m4_dp_q[j]) << (j * DW));
    end
    for (int j = 0; j < 4; j++) begin
      m7_den_d = m7_den_d + (DenW'(m6_np_q[j]) << (j * DW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_d2_q   <= m1_d2_d;
      m1_ge_q   <= m1_ge_d;
      m1_d_q    <= e2_d_q;
      m1_n_q    <= e2_n_q;
      m1_zero_q <= e2_zero_q;
      m1_neg_q  <= e2_neg_q;
      m1_mag_q  <= e2_mag_q;

      m2_p0_q   <= m2_p0_d;
      m2_p1_q   <= m2_p1_d;
      m2_g0_q   <= m2_g0_d;
      m2_g1_q   <= m2_g1_d;
      m2_n_q    <= m1_n_q;
      m2_zero_q <= m1_zero_q;
      m2_neg_q  <= m1_neg_q;

      m3_d3_q   <= D3W'(m2_p0_q) + (D3W'(m2_p1_q) << DW);
      for (int i = 0; i < 3; i++) begin
        m3_num_q[i] <= NbW'(m2_g0_q[i]) + (NbW'(m2_g1_q[i]) << 32);
      end
      m3_n_q    <= m2_n_q;
      m3_zero_q <= m2_zero_q;
      m3_neg_q  <= m2_neg_q;

      m4_dp_q   <= m4_dp_d;
      m4_num_q  <= m3_num_q;
      m4_n_q    <= m3_n_q;
      m4_zero_q <= m3_zero_q;
      m4_neg_q  <= m3_neg_q;

      m5_dd_q   <= m5_dd_d;
      m5_num_q  <= m4_num_q;
      m5_n_q    <= m4_n_q;
      m5_zero_q <= m4_zero_q;
      m5_neg_q  <= m4_neg_q;

      m6_np_q   <= m6_np_d;
      m6_num_q  <= m5_num_q;
      m6_zero_q <= m5_zero_q;
      m6_neg_q  <= m5_neg_q;

      m7_den_q  <= m7_den_d;
      m7_num_q  <= m6_num_q;
      m7_zero_q <= m6_zero_q;
      m7_neg_q  <= m6_neg_q;
    end
  end

  // ---------------- divider entry and restoring division, one quotient bit per stage
  logic [DenW-1:0] dv_rem_q  [QW+1][3];
  logic [QW-1:0]   dv_lo_q   [QW+1][3];
  logic [QW-1:0]   dv_quo_q  [QW+1][3];
  logic [2:0]      dv_big_q  [QW+1];
  logic [DenW-1:0] dv_den_q  [QW+1];
  logic [2:0]      dv_neg_q  [QW+1];
  logic            dv_zero_q [QW+1];
  logic [NumW-1:0] dv_numf   [3];

  // numerator with the 2^(3F) scale applied
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_numf[i] = NumW'(m7_num_q[i]) << (3 * FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= DenW'(dv_numf[i][NumW-1 -: HiW]);
        dv_lo_q[0][i]  <= dv_numf[i][QW-1:0];
        dv_quo_q[0][i] <= '0;
        // quotient would not fit in QW bits
        dv_big_q[0][i] <= DenW'(dv_numf[i][NumW-1 -: HiW]) >= m7_den_q;
      end
      dv_den_q[0]  <= m7_den_q;
      dv_neg_q[0]  <= m7_neg_q;
      dv_zero_q[0] <= m7_zero_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DenW:0] rem2 [3];
    logic [2:0]    take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {dv_rem_q[k][i], dv_lo_q[k][i][QW-1]};
        take[i] = rem2[i] >= {1'b0, dv_den_q[k]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k+1][i] <= take[i] ? DenW'(rem2[i] - {1'b0, dv_den_q[k]})
                                      : rem2[i][DenW-1:0];
          dv_lo_q[k+1][i]  <= dv_lo_q[k][i] << 1;
          dv_quo_q[k+1][i] <= {dv_quo_q[k][i][QW-2:0], take[i]};
        end
        dv_big_q[k+1]  <= dv_big_q[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
      end
    end
  end

  // ---------------- output: sign, saturation and zero force
  logic [OutW-1:0] out_f_d [3];
  logic [2:0]      out_c_d;
  logic [OutW-1:0] out_f_q [3];
  logic            out_sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_f_d[i] = '0;
      out_c_d[i] = 1'b0;
      if (!dv_zero_q[QW]) begin
        if (!dv_neg_q[QW][i]) begin
          if (dv_big_q[QW][i] || dv_quo_q[QW][i][QW-1]) begin
            out_f_d[i] = OutMax;
            out_c_d[i] = 1'b1;
          end else begin
            out_f_d[i] = dv_quo_q[QW][i];
          end
        end else begin
          if (dv_big_q[QW][i] || (dv_quo_q[QW][i] > OutMin)) begin
            out_f_d[i] = OutMin;
            out_c_d[i] = 1'b1;
          end else begin
            out_f_d[i] = ~dv_quo_q[QW][i] + OutW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_f_q   <= out_f_d;
      out_sat_q <= |out_c_d;
    end
  end

  assign force_x_o   = out_f_q[0];
  assign force_y_o   = out_f_q[1];
  assign force_z_o   = out_f_q[2];
  assign saturated_o = out_sat_q;

  // ---------------- assertions
  a_freeze_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved while stalled");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SqEnd] |-> sq_rem_q[RootW] <= SumW'({sq_root_q[RootW], 1'b0}))
    else $error("square root remainder exceeds twice the root");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSt-2] && !dv_zero_q[QW] && !dv_big_q[QW][0] |->
      dv_rem_q[QW][0] < dv_den_q[QW])
    else $error("division remainder not below divisor");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      force_x_o == OutMax || force_x_o == OutMin ||
      force_y_o == OutMax || force_y_o == OutMin ||
      force_z_o == OutMax || force_z_o == OutMin)
    else $error("saturation flagged with no component at a limit");

endmodule
